// File: rtl/core/skt_pkg.sv
package skt_pkg;

  localparam int KEY_W  = 27;
  localparam int AGE_W  = 8;
  localparam int RIDX_W = 6;
  localparam int POS_W  = 7;
  localparam int ST_W   = 3;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_DELETE = 2'd1,
    OP_READ   = 2'd2,
    OP_UNUSED = 2'd3
  } op_t;

  typedef enum logic [ST_W-1:0] {
    ST_INSERTED  = 3'd0,
    ST_DUPLICATE = 3'd1,
    ST_FULL      = 3'd2,
    ST_DELETED   = 3'd3,
    ST_NOT_FOUND = 3'd4,
    ST_READ_OK   = 3'd5,
    ST_BAD_INDEX = 3'd6
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_START,
    S_SEARCH,
    S_DECIDE,
    S_SHUP,
    S_PUT,
    S_SHDN,
    S_READ,
    S_DONE
  } state_t;

  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [AGE_W-1:0] age;
  } entry_t;

  typedef struct packed {
    op_t               op;
    logic [KEY_W-1:0]  key;
    logic [AGE_W-1:0]  age;
    logic [RIDX_W-1:0] read_index;
  } cmd_t;

  typedef struct packed {
    status_t          status;
    logic [POS_W-1:0] position;
    logic [KEY_W-1:0] key;
    logic [AGE_W-1:0] age;
    logic [POS_W-1:0] count;
  } res_t;

endpackage

// File: rtl/core/skt_ram.sv
module skt_ram #(
  parameter int WIDTH = 35,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: rtl/core/skt_engine.sv
module skt_engine #(
  parameter int CAPACITY = 64
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          cmd_valid,
  output logic          cmd_ready,
  input  skt_pkg::cmd_t cmd,
  output logic          res_valid,
  input  logic          res_ready,
  output skt_pkg::res_t res
);
  import skt_pkg::*;

  localparam int IDX_W = $clog2(CAPACITY);
  localparam int CNT_W = $clog2(CAPACITY + 1);

  state_t           state_r, state_nxt;
  cmd_t             cmd_r, cmd_nxt;
  res_t             res_r, res_nxt;
  logic [CNT_W-1:0] fill_r, fill_nxt;
  logic [CNT_W-1:0] ptr_r, ptr_nxt;
  logic [CNT_W-1:0] pos_r, pos_nxt;
  logic             hit_r, hit_nxt;

  logic             ram_we, ram_re;
  logic [IDX_W-1:0] ram_waddr, ram_raddr;
  entry_t           ram_wdata, rd_ent;
  logic [$bits(entry_t)-1:0] ram_rdata;

  logic [CNT_W-1:0] ptr_inc, ptr_dec, pos_inc, fill_inc, fill_dec;
  logic             ri_fits, tbl_full;

  skt_ram #(
    .WIDTH($bits(entry_t)),
    .DEPTH(CAPACITY)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  assign rd_ent   = entry_t'(ram_rdata);
  assign ptr_inc  = ptr_r + CNT_W'(1);
  assign ptr_dec  = ptr_r - CNT_W'(1);
  assign pos_inc  = pos_r + CNT_W'(1);
  assign fill_inc = fill_r + CNT_W'(1);
  assign fill_dec = fill_r - CNT_W'(1);
  assign ri_fits  = 32'(cmd_r.read_index) < 32'(fill_r);
  assign tbl_full = fill_r == CNT_W'(CAPACITY);

  assign cmd_ready = state_r == S_IDLE;
  assign res_valid = state_r == S_DONE;
  assign res       = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      fill_r  <= '0;
    end else begin
      state_r <= state_nxt;
      fill_r  <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r <= cmd_nxt;
    res_r <= res_nxt;
    ptr_r <= ptr_nxt;
    pos_r <= pos_nxt;
    hit_r <= hit_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (cmd_valid) begin
          state_nxt = S_START;
        end
      end
      S_START: begin
        unique case (cmd_r.op) inside
          OP_INSERT, OP_DELETE: state_nxt = (fill_r == '0) ? S_DECIDE : S_SEARCH;
          OP_READ:              state_nxt = ri_fits ? S_READ : S_DONE;
          default:              state_nxt = S_DONE;
        endcase
      end
      S_SEARCH: begin
        if (!(rd_ent.key < cmd_r.key) || ptr_inc == fill_r) begin
          state_nxt = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (cmd_r.op == OP_INSERT) begin
          if (hit_r || tbl_full) begin
            state_nxt = S_DONE;
          end else if (pos_r == fill_r) begin
            state_nxt = S_PUT;
          end else begin
            state_nxt = S_SHUP;
          end
        end else if (!hit_r || pos_inc == fill_r) begin
          state_nxt = S_DONE;
        end else begin
          state_nxt = S_SHDN;
        end
      end
      S_SHUP: begin
        if (ptr_r == pos_r) begin
          state_nxt = S_PUT;
        end
      end
      S_PUT: state_nxt = S_DONE;
      S_SHDN: begin
        if (ptr_inc == fill_r) begin
          state_nxt = S_DONE;
        end
      end
      S_READ: state_nxt = S_DONE;
      S_DONE: begin
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_nxt   = cmd_r;
    res_nxt   = res_r;
    fill_nxt  = fill_r;
    ptr_nxt   = ptr_r;
    pos_nxt   = pos_r;
    hit_nxt   = hit_r;
    ram_we    = 1'b0;
    ram_waddr = '0;
    ram_wdata = '0;
    ram_re    = 1'b0;
    ram_raddr = '0;

    unique case (state_r)
      S_IDLE: begin
        if (cmd_valid) begin
          cmd_nxt = cmd;
        end
      end
      S_START: begin
        res_nxt = '{status: ST_BAD_INDEX, position: '0, key: '0, age: '0,
                    count: POS_W'(fill_r)};
        unique case (cmd_r.op) inside
          OP_INSERT, OP_DELETE: begin
            pos_nxt   = '0;
            hit_nxt   = 1'b0;
            ptr_nxt   = '0;
            ram_re    = fill_r != '0;
            ram_raddr = '0;
          end
          OP_READ: begin
            res_nxt.position = POS_W'(cmd_r.read_index);
            ram_re           = ri_fits;
            ram_raddr        = IDX_W'(cmd_r.read_index);
          end
          default: ;
        endcase
      end
      S_SEARCH: begin
        // Fetch the next entry while comparing the one that just arrived.
        if (rd_ent.key < cmd_r.key) begin
          ptr_nxt   = ptr_inc;
          pos_nxt   = ptr_inc;
          ram_re    = ptr_inc != fill_r;
          ram_raddr = ptr_inc[IDX_W-1:0];
        end else begin
          pos_nxt = ptr_r;
          hit_nxt = rd_ent.key == cmd_r.key;
        end
      end
      S_DECIDE: begin
        res_nxt.position = POS_W'(pos_r);
        if (cmd_r.op == OP_INSERT) begin
          if (hit_r) begin
            res_nxt.status = ST_DUPLICATE;
          end else if (tbl_full) begin
            res_nxt.status = ST_FULL;
          end else begin
            ptr_nxt   = fill_dec;
            ram_re    = pos_r != fill_r;
            ram_raddr = fill_dec[IDX_W-1:0];
          end
        end else if (!hit_r) begin
          res_nxt.status = ST_NOT_FOUND;
        end else begin
          res_nxt.status = ST_DELETED;
          if (pos_inc == fill_r) begin
            fill_nxt      = fill_dec;
            res_nxt.count = POS_W'(fill_dec);
          end else begin
            ptr_nxt   = pos_inc;
            ram_re    = 1'b1;
            ram_raddr = pos_inc[IDX_W-1:0];
          end
        end
      end
      S_SHUP: begin
        // Reads walk down ahead of the writes, two entries below them, so the two never meet.
        ram_we    = 1'b1;
        ram_waddr = ptr_inc[IDX_W-1:0];
        ram_wdata = rd_ent;
        if (ptr_r != pos_r) begin
          ptr_nxt   = ptr_dec;
          ram_re    = 1'b1;
          ram_raddr = ptr_dec[IDX_W-1:0];
        end
      end
      S_PUT: begin
        ram_we         = 1'b1;
        ram_waddr      = pos_r[IDX_W-1:0];
        ram_wdata      = '{key: cmd_r.key, age: cmd_r.age};
        fill_nxt       = fill_inc;
        res_nxt.status = ST_INSERTED;
        res_nxt.count  = POS_W'(fill_inc);
      end
      S_SHDN: begin
        ram_we    = 1'b1;
        ram_waddr = ptr_dec[IDX_W-1:0];
        ram_wdata = rd_ent;
        if (ptr_inc == fill_r) begin
          fill_nxt      = fill_dec;
          res_nxt.count = POS_W'(fill_dec);
        end else begin
          ptr_nxt   = ptr_inc;
          ram_re    = 1'b1;
          ram_raddr = ptr_inc[IDX_W-1:0];
        end
      end
      S_READ: begin
        res_nxt.status = ST_READ_OK;
        res_nxt.key    = rd_ent.key;
        res_nxt.age    = rd_ent.age;
      end
      S_DONE: ;
      default: ;
    endcase
  end

`ifndef ASSERT_OFF
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(fill_r) <= CAPACITY)
    else $error("fill count above capacity");

  a_fill_step: assert property (@(posedge clk) disable iff (!rst_n)
    (fill_r != $past(fill_r)) |->
      (fill_r == $past(fill_r) + CNT_W'(1) || fill_r == $past(fill_r) - CNT_W'(1)))
    else $error("fill count moved by more than one");

  a_no_rw_clash: assert property (@(posedge clk) disable iff (!rst_n)
    (ram_we && ram_re) |-> (ram_waddr != ram_raddr))
    else $error("read and write to the same entry in one cycle");

  a_shift_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SHUP) |-> (ptr_r >= pos_r && ptr_r < fill_r))
    else $error("upward shift pointer out of range");
`endif

endmodule

// File: rtl/core/sorted_key_table_unit.sv
// Channel  Direction  Handshake             Payload
// in_      input      in_valid/in_ready     op, key, age_in, read_index
// out_     output     out_valid/out_ready   status, position, key_out, age_out, entry_count
//
// One transaction at a time goes through a single table RAM (one write, one read port).
// An insert or delete first searches the sorted entries and then, if accepted, shifts any
// entries behind the position up or down; a read fetches the entry at read_index. The
// search compares one entry per cycle and the shift moves one entry per cycle.
// Reset clears the entry count, the engine state and out_valid; the RAM contents stay as they were.
// in_ready rises in the cycle out_valid does; while out_ready is low the output register
// holds its result, and one more input is taken and processed, then held in the engine.
module sorted_key_table_unit #(
  parameter int CAPACITY = 64
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [1:0]                    in_op,
  input  logic [skt_pkg::KEY_W-1:0]     in_key,
  input  logic [skt_pkg::AGE_W-1:0]     in_age_in,
  input  logic [skt_pkg::RIDX_W-1:0]    in_read_index,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [skt_pkg::ST_W-1:0]      out_status,
  output logic [skt_pkg::POS_W-1:0]     out_position,
  output logic [skt_pkg::KEY_W-1:0]     out_key_out,
  output logic [skt_pkg::AGE_W-1:0]     out_age_out,
  output logic [skt_pkg::POS_W-1:0]     out_entry_count
);
  import skt_pkg::*;

  cmd_t cmd;
  res_t eng_res;
  res_t out_r;
  logic eng_res_valid, eng_res_ready;
  logic out_valid_r, out_valid_nxt;

  assign cmd = '{op: op_t'(in_op), key: in_key, age: in_age_in, read_index: in_read_index};

  skt_engine #(
    .CAPACITY(CAPACITY)
  ) u_engine (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd_valid(in_valid),
    .cmd_ready(in_ready),
    .cmd      (cmd),
    .res_valid(eng_res_valid),
    .res_ready(eng_res_ready),
    .res      (eng_res)
  );

  assign eng_res_ready = !out_valid_r || out_ready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (eng_res_ready) begin
      out_valid_nxt = eng_res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (eng_res_valid && eng_res_ready) begin
      out_r <= eng_res;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_r.status;
  assign out_position    = out_r.position;
  assign out_key_out     = out_r.key;
  assign out_age_out     = out_r.age;
  assign out_entry_count = out_r.count;

endmodule
